### hw/rtl/dsf_pkg.sv
// ----------------------------------------------------------------------------
// dsf_pkg
// shared types, character codes and the power-of-ten table for the decimal
// string to fixed-point converter
// ----------------------------------------------------------------------------
package dsf_pkg;

  // character codes
  localparam logic [15:0] CH_TERM  = 16'h0000;
  localparam logic [15:0] CH_POINT = 16'h002E;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;
  localparam logic [15:0] CH_MINUS = 16'h002D;

  localparam logic [31:0] DEC_RADIX = 32'd10;

  // fraction length counter, holds up to 20
  localparam int LEN_W = 5;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // one finished string, handed from front to back
  typedef struct packed {
    logic [31:0]      mag;         // signed integer part after the sign
    logic             neg;         // fraction term is subtracted
    logic             in_fraction; // a point was seen
    logic [31:0]      frac_accum;
    logic [LEN_W-1:0] frac_chars;
  } job_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [LEVEL_W-1:0] level;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_FINISH,
    BK_OUTPUT
  } back_state_t;

  function automatic logic [63:0] pow10(input logic [LEN_W-1:0] idx);
    logic [63:0] p;
    unique case (idx)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

### hw/rtl/dsf_char_if.sv
// ----------------------------------------------------------------------------
// dsf_char_if
// character stream channel, one 16-bit code per transaction
// ----------------------------------------------------------------------------
interface dsf_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

### hw/rtl/dsf_result_if.sv
// ----------------------------------------------------------------------------
// dsf_result_if
// result channel, one parsed Q32.32 value per transaction
// ----------------------------------------------------------------------------
interface dsf_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value_q32_32;
  logic               point_seen;

  modport source (output valid, output value_q32_32, output point_seen, input ready);
  modport sink   (input valid, input value_q32_32, input point_seen, output ready);
endinterface

### hw/rtl/dsf_front.sv
// ----------------------------------------------------------------------------
// dsf_front
// character parser: builds integer and fraction accumulators, pushes a job
// into the queue on every terminator
// ----------------------------------------------------------------------------
module dsf_front #(
  parameter int MAX_FRAC_LEN = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  dsf_char_if.sink              chars,
  input  dsf_pkg::queue_status_t qstat,
  output logic                  push,
  output dsf_pkg::job_t         job
);
  import dsf_pkg::*;

  logic             at_first_char;
  logic             minus_sign;
  logic             in_fraction;
  logic             past_second_point;
  logic [31:0]      integer_accum;
  logic [31:0]      fraction_accum;
  logic [LEN_W-1:0] fraction_length;

  logic        accept;
  logic        is_digit;
  logic [31:0] digit_val;
  logic [31:0] mag;

  assign chars.ready = !qstat.full;
  assign accept      = chars.valid && chars.ready;
  assign is_digit    = (chars.char_code >= CH_ZERO) && (chars.char_code <= CH_NINE);
  assign digit_val   = 32'(chars.char_code[3:0]);
  assign push        = accept && (chars.char_code == CH_TERM);

  assign mag              = minus_sign ? (32'd0 - integer_accum) : integer_accum;
  assign job.mag          = mag;
  assign job.neg          = mag[31] || minus_sign;
  assign job.in_fraction  = in_fraction;
  assign job.frac_accum   = fraction_accum;
  assign job.frac_chars   = fraction_length;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      at_first_char     <= 1'b1;
      minus_sign        <= 1'b0;
      in_fraction       <= 1'b0;
      past_second_point <= 1'b0;
      integer_accum     <= '0;
      fraction_accum    <= '0;
      fraction_length   <= '0;
    end else if (accept) begin
      at_first_char <= 1'b0;
      if (!in_fraction) begin
        if (chars.char_code == CH_POINT) begin
          in_fraction <= 1'b1;
        end else if (at_first_char && chars.char_code == CH_MINUS) begin
          minus_sign <= 1'b1;
        end else if (is_digit) begin
          integer_accum <= integer_accum * DEC_RADIX + digit_val;
        end
      end else begin
        if (fraction_length < LEN_W'(MAX_FRAC_LEN)) begin
          fraction_length <= fraction_length + 1'b1;
        end
        if (chars.char_code == CH_POINT) begin
          past_second_point <= 1'b1;
        end else if (is_digit && !past_second_point) begin
          fraction_accum <= fraction_accum * DEC_RADIX + digit_val;
        end
      end
    end
  end

endmodule

### hw/rtl/dsf_queue.sv
// ----------------------------------------------------------------------------
// dsf_queue
// short job queue in flip-flops between parser and divider
// ----------------------------------------------------------------------------
module dsf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  dsf_pkg::job_t          wr_job,
  input  logic                   pop,
  output dsf_pkg::job_t          rd_job,
  output dsf_pkg::queue_status_t qstat
);
  import dsf_pkg::*;

  job_t               entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] level;

  assign rd_job      = entries[rd_ptr];
  assign qstat.level = level;
  assign qstat.full  = (level == LEVEL_W'(QUEUE_DEPTH));
  assign qstat.empty = (level == '0);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/dsf_back.sv
// ----------------------------------------------------------------------------
// dsf_back
// result unit: bit-serial restoring divider for the fraction term, then
// signed add with saturation into the output register
// ----------------------------------------------------------------------------
module dsf_back #(
  parameter int FRAC_BITS    = 32,
  parameter int MAX_FRAC_LEN = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dsf_pkg::queue_status_t qstat,
  input  dsf_pkg::job_t          job,
  output logic                   pop,
  dsf_result_if.source           results
);
  import dsf_pkg::*;

  localparam int DW    = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(DW);

  back_state_t state, state_next;

  logic [63:0]    base;
  logic [63:0]    room;
  logic           neg;
  logic           point;
  logic [63:0]    den;
  logic [63:0]    rem;
  logic [DW-1:0]  quo;   // dividend shifts out, quotient shifts in
  logic [CNT_W-1:0] cnt;
  logic [63:0]    out_value;
  logic           out_point;

  logic        do_div;
  logic [63:0] job_base;
  logic [64:0] rem_sh;
  logic        fits;
  logic [63:0] term;

  assign do_div   = job.in_fraction && (job.frac_chars != '0) &&
                    (job.frac_chars < LEN_W'(MAX_FRAC_LEN));
  assign job_base = {{32{job.mag[31]}}, job.mag} << FRAC_BITS;
  assign rem_sh   = {rem, quo[DW-1]};
  assign fits     = rem_sh >= {1'b0, den};
  assign term     = 64'(quo);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!qstat.empty) begin
          state_next = do_div ? BK_DIVIDE : BK_FINISH;
        end
      end
      BK_DIVIDE: begin
        if (cnt == '0) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: state_next = BK_OUTPUT;
      BK_OUTPUT: begin
        if (results.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop           = 1'b0;
    results.valid = 1'b0;
    unique case (state)
      BK_IDLE:   pop = !qstat.empty;
      BK_OUTPUT: results.valid = 1'b1;
      default: begin
      end
    endcase
  end

  assign results.value_q32_32 = out_value;
  assign results.point_seen   = out_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        base  <= job_base;
        neg   <= job.neg;
        point <= job.in_fraction;
        room  <= job.neg ? (job_base ^ SAT_MIN) : (SAT_MAX - job_base);
        den   <= pow10(job.frac_chars);
        rem   <= '0;
        quo   <= do_div ? DW'({job.frac_accum, {FRAC_BITS{1'b0}}}) : '0;
        cnt   <= CNT_W'(DW - 1);
      end
      BK_DIVIDE: begin
        rem <= fits ? 64'(rem_sh - {1'b0, den}) : rem_sh[63:0];
        quo <= {quo[DW-2:0], fits};
        cnt <= cnt - 1'b1;
      end
      BK_FINISH: begin
        out_point <= point;
        if (term > room) begin
          out_value <= neg ? SAT_MIN : SAT_MAX;
        end else begin
          out_value <= neg ? (base - term) : (base + term);
        end
      end
      BK_OUTPUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/decimal_string_to_fixed.sv
// ----------------------------------------------------------------------------
// decimal_string_to_fixed
// parses a decimal character string into a saturated signed Q32.32 value
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                          transaction
//   chars     in    char_code[15:0]                  one character, 0 ends string
//   results   out   value_q32_32[63:0], point_seen   one per terminator
//
// the parser takes one character per cycle while the job queue has room
// a terminator queues a job; the result unit goes from idle to finish and then
// to output, where it waits on the handshake; with a fraction term it runs the
// one-bit-per-cycle restoring divider (32 + FRAC_BITS steps) before finish
// two jobs can wait in the queue; when it is full the chars channel stalls
// a stalled result holds in the output register; rst is synchronous, no
// clearing pass is needed
//
module decimal_string_to_fixed #(
  parameter int FRAC_BITS    = 32,
  parameter int MAX_FRAC_LEN = 20
) (
  input  logic          clk,
  input  logic          rst,
  dsf_char_if.sink      chars,
  dsf_result_if.source  results
);
  import dsf_pkg::*;

  // handoff between front and back
  logic          push;
  logic          pop;
  job_t          wr_job;
  job_t          rd_job;
  queue_status_t qstat;

  // front: character classification and accumulation
  dsf_front #(
    .MAX_FRAC_LEN (MAX_FRAC_LEN)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .qstat (qstat),
    .push  (push),
    .job   (wr_job)
  );

  // decoupling queue, lets the parser run on during a division
  dsf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .qstat  (qstat)
  );

  // back: fraction division, sign and saturation
  dsf_back #(
    .FRAC_BITS    (FRAC_BITS),
    .MAX_FRAC_LEN (MAX_FRAC_LEN)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .qstat   (qstat),
    .job     (rd_job),
    .pop     (pop),
    .results (results)
  );

  // the back only takes a job from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("job taken from an empty queue");

  // a terminator with no job taken in the same cycle raises the fill level
  a_push_level: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (qstat.level == $past(qstat.level) + 1'b1))
    else $error("queue level did not follow a pushed job");

  // no new job is started while a result is still offered
  a_no_pop_while_out: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !pop)
    else $error("job taken while a result is pending");

  // a full queue must hold the character channel off
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !chars.ready)
    else $error("characters accepted with the queue full");

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks decimal_string_to_fixed against a behavioural parser kept in the
// bench: directed strings first, then random strings, with random gaps on
// both channels and every result compared field by field in order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dsf_pkg::*;

  // '+' is not in the package; it is skipped, only a leading minus acts as a sign
  localparam logic [15:0] CH_PLUS = 16'h002B;

  localparam int FRAC_LEN_CAP = 20;     // fraction length holds here, term drops to 0
  localparam int IDLE_PCT     = 23;     // chance of a gap per cycle on either side
  localparam int RANDOM_CHARS = 1630;   // least number of characters in the random part
  localparam int DRAIN_CYCLES = 120;    // longest divide plus output handshake, with margin
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [63:0] value;
    logic               point;
  } fixed_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // bench-side drive registers, known from time zero
  logic        char_valid   = 1'b0;
  logic [15:0] char_data    = 16'h0000;
  logic        result_ready = 1'b0;
  logic        char_taken   = 1'b0;

  logic [15:0]   char_backlog[$];     // characters waiting to be driven
  fixed_result_t pending_results[$];  // parsed values still owed by the block

  int  sent_count = 0;
  int  failures   = 0;
  logic calm;

  // mirror of the parser state
  logic        at_start;
  logic        neg_sign;
  logic        frac_mode;
  logic        frac_closed;
  logic [31:0] int_acc;
  logic [31:0] frac_acc;
  logic [4:0]  frac_chars;

  string directed_cases[] = '{
    "",                            // empty string
    "-",                           // sign only
    "+7",                          // plus is skipped, value positive
    "-2147483648",                 // negating the most negative integer wraps
    "4294967299",                  // integer wraps modulo 2^32
    "2147483648.5",                // wrapped negative integer, fraction subtracted, saturates
    "-2147483648.25",              // bottom of the range, saturates low
    "-0.5",
    "-.5",
    ".",                           // point with no fraction digits
    "12a3.4-5",                    // non-digits skipped in both parts
    "--5",                         // second minus is just skipped
    "+-5",                         // minus not first, so not a sign
    "1.2.3",                       // digits after a second point ignored
    "0.4294967295",                // largest fraction value
    "0.9999999999",                // fraction wraps
    "0.1234567890123456789",       // longest fraction still giving a term
    "0.12345678901234567890",      // length reaches the cap, term is 0
    "3.14159265358979323846264",   // length saturates past the cap
    "2147483647.999999999",        // top of the positive range
    "-0"
  };

  dsf_char_if   chars_bus();
  dsf_result_if results_bus();

  assign chars_bus.valid     = char_valid;
  assign chars_bus.char_code = char_data;
  assign results_bus.ready   = result_ready;

  // long stretch with no gaps on either side
  assign calm = (sent_count >= 700) && (sent_count < 1100);

  decimal_string_to_fixed uut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_bus),
    .results (results_bus)
  );

  initial forever #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // bench parser
  // --------------------------------------------------------------------------
  function automatic logic [63:0] ten_power(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  // integer part in the top half, fraction term added or taken off, saturated
  function automatic logic [63:0] fixed_value();
    logic [31:0] whole_part;
    logic [63:0] scaled;
    logic [63:0] term;
    logic [63:0] headroom;
    whole_part = neg_sign ? (32'd0 - int_acc) : int_acc;
    scaled     = {whole_part, 32'h0000_0000};
    term       = 64'd0;
    if (!frac_mode) return scaled;
    if (frac_chars != 5'd0 && frac_chars < FRAC_LEN_CAP)
      term = {frac_acc, 32'h0000_0000} / ten_power(frac_chars);
    if (whole_part[31] || neg_sign) begin
      headroom = scaled - SAT_MIN;
      return (term > headroom) ? SAT_MIN : scaled - term;
    end
    headroom = SAT_MAX - scaled;
    return (term > headroom) ? SAT_MAX : scaled + term;
  endfunction

  task automatic clear_parser();
    at_start    = 1'b1;
    neg_sign    = 1'b0;
    frac_mode   = 1'b0;
    frac_closed = 1'b0;
    int_acc     = 32'd0;
    frac_acc    = 32'd0;
    frac_chars  = 5'd0;
  endtask

  // one accepted character; a terminator owes one result
  task automatic take_char(input logic [15:0] code);
    logic        first;
    logic        is_digit;
    logic [31:0] digit_val;
    first     = at_start;
    is_digit  = (code >= CH_ZERO) && (code <= CH_NINE);
    digit_val = {16'h0000, code - CH_ZERO};
    if (code == CH_TERM) begin
      pending_results.push_back('{value: fixed_value(), point: frac_mode});
      clear_parser();
    end else begin
      at_start = 1'b0;
      if (!frac_mode) begin
        if (code == CH_POINT) frac_mode = 1'b1;
        else if (first && code == CH_MINUS) neg_sign = 1'b1;
        else if (is_digit) int_acc = int_acc * DEC_RADIX + digit_val;
      end else begin
        if (frac_chars < FRAC_LEN_CAP) frac_chars = frac_chars + 5'd1;
        if (code == CH_POINT) frac_closed = 1'b1;
        else if (is_digit && !frac_closed) frac_acc = frac_acc * DEC_RADIX + digit_val;
      end
    end
  endtask

  task automatic report_failure(input string what);
    failures++;
    if (failures <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  task automatic push_text(input string text);
    for (int i = 0; i < text.len(); i++) char_backlog.push_back({8'h00, text[i]});
  endtask

  // --------------------------------------------------------------------------
  // character driver: a held transaction is never withdrawn, gaps only
  // fall between transactions
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || char_taken) begin
      if (char_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        char_valid <= 1'b1;
        char_data  <= char_backlog.pop_front();
        sent_count++;
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // result sink stalls at random outside the calm stretch
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: characters feed the bench parser, results are checked in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    fixed_result_t want;
    if (rst) begin
      char_taken <= 1'b0;
    end else begin
      char_taken <= chars_bus.valid && chars_bus.ready;
      if (chars_bus.valid && chars_bus.ready) take_char(chars_bus.char_code);
      if (results_bus.valid && results_bus.ready) begin
        if (pending_results.size() == 0) begin
          report_failure($sformatf("unexpected result %h point %b",
                                   results_bus.value_q32_32, results_bus.point_seen));
        end else begin
          want = pending_results.pop_front();
          if (results_bus.value_q32_32 !== want.value)
            report_failure($sformatf("value: expected %h got %h",
                                     want.value, results_bus.value_q32_32));
          if (results_bus.point_seen !== want.point)
            report_failure($sformatf("point_seen: expected %b got %b",
                                     want.point, results_bus.point_seen));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int random_chars;
    int start_size;
    int pick;
    int flen;
    int r;
    clear_parser();

    // directed strings, each followed by its terminator
    foreach (directed_cases[i]) begin
      push_text(directed_cases[i]);
      char_backlog.push_back(CH_TERM);
    end
    // codes with the top bits set, then a digit
    char_backlog.push_back(16'hFFFF);
    char_backlog.push_back(16'h8000);
    char_backlog.push_back(CH_NINE);
    char_backlog.push_back(CH_TERM);

    // random strings: mostly well formed, some pure noise
    random_chars = 0;
    while (random_chars < RANDOM_CHARS) begin
      start_size = char_backlog.size();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(0, 8))
          char_backlog.push_back(16'($urandom_range(1, 65535)));
      end else begin
        r = $urandom_range(0, 3);
        if (r == 1) char_backlog.push_back(CH_MINUS);
        else if (r == 2) char_backlog.push_back(CH_PLUS);
        if ($urandom_range(0, 99) < 5) begin
          // integer at the wrap point, pushes the result towards saturation
          push_text($urandom_range(0, 1) ? "2147483648" : "2147483647");
        end else begin
          repeat ($urandom_range(0, 11)) begin
            if ($urandom_range(0, 99) < 6)
              char_backlog.push_back(16'($urandom_range(1, 65535)));
            else
              char_backlog.push_back(CH_ZERO + 16'($urandom_range(0, 9)));
          end
        end
        if ($urandom_range(0, 99) < 85) begin
          char_backlog.push_back(CH_POINT);
          flen = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 9);
          repeat (flen) begin
            r = $urandom_range(0, 99);
            if (r < 3) char_backlog.push_back(CH_POINT);
            else if (r < 8) char_backlog.push_back(16'($urandom_range(1, 65535)));
            else char_backlog.push_back(CH_ZERO + 16'($urandom_range(0, 9)));
          end
        end
      end
      char_backlog.push_back(CH_TERM);
      random_chars += char_backlog.size() - start_size;
    end

    // synchronous reset, released away from the active edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every character accepted, then every result back, then let it settle
    while (char_backlog.size() != 0 || chars_bus.valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", pending_results.size()));
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/dsf_pkg.sv
hw/rtl/dsf_char_if.sv
hw/rtl/dsf_result_if.sv
hw/rtl/dsf_front.sv
hw/rtl/dsf_queue.sv
hw/rtl/dsf_back.sv
hw/rtl/decimal_string_to_fixed.sv
bench/testbench.sv
